FILE: hdl/gprb_pkg.sv
// Shared types, register select codes and mask helpers for the GPIO port register block.
// No dependencies; every other file imports this package.
`default_nettype none
package gprb_pkg;

  localparam int DEF_PIN_COUNT = 16;
  localparam int MAX_PINS = 16;
  localparam logic [63:0] CFG_RESET = 64'h4444_4444_4444_4444;

  typedef enum logic [2:0] {
    SEL_CRL  = 3'd0,
    SEL_CRH  = 3'd1,
    SEL_IDR  = 3'd2,
    SEL_ODR  = 3'd3,
    SEL_BSRR = 3'd4,
    SEL_BRR  = 3'd5,
    SEL_LCKR = 3'd6
  } sel_t;

  typedef struct packed {
    logic        req_type;
    logic [2:0]  reg_select;
    logic [31:0] write_data;
    logic [15:0] pin_levels;
  } req_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic [15:0] output_levels;
    logic        lock_active;
  } rsp_t;

  typedef struct packed {
    logic        locked;
    logic [15:0] bits;
  } lock_status_t;

  function automatic logic [15:0] pin_mask(input int count);
    logic [15:0] m;
    for (int i = 0; i < MAX_PINS; i++) begin
      m[i] = (i < count);
    end
    return m;
  endfunction

  function automatic logic [63:0] pins_to_nibbles(input logic [15:0] pins);
    logic [63:0] m;
    for (int i = 0; i < MAX_PINS; i++) begin
      m[4*i +: 4] = {4{pins[i]}};
    end
    return m;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/gprb_if.sv
// Valid/ready channel interfaces for bus requests and responses.
// Depends on gprb_pkg for the payload structs.
`default_nettype none
interface gprb_req_if import gprb_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gprb_rsp_if import gprb_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/gprb_lock.sv
// Lock key sequencer and lock bit register of the port.
// Depends on gprb_pkg.
`default_nettype none
module gprb_lock import gprb_pkg::*; #(
  parameter int PIN_COUNT = DEF_PIN_COUNT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire logic [16:0]  wr_data,
  output lock_status_t      status,
  output lock_status_t      status_next
);

  localparam logic [15:0] PIN_MASK = pin_mask(PIN_COUNT);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_FIRST  = 3'b010,
    ST_SECOND = 3'b100
  } step_t;

  step_t       step;
  step_t       step_next;
  logic        locked;
  logic        locked_next;
  logic [15:0] bits;
  logic [15:0] bits_next;
  logic [15:0] pins;
  logic        key;

  assign pins = wr_data[15:0] & PIN_MASK;
  assign key  = wr_data[16];

  always_comb begin
    step_next   = step;
    locked_next = locked;
    bits_next   = bits;
    if (wr_en && !locked) begin
      bits_next = pins;
      step_next = key ? ST_FIRST : ST_IDLE;
      unique case (step)
        ST_FIRST: begin
          if (!key && pins == bits) begin
            step_next = ST_SECOND;
          end
        end
        ST_SECOND: begin
          if (key && pins == bits) begin
            locked_next = 1'b1;
            step_next   = ST_IDLE;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= ST_IDLE;
      locked <= 1'b0;
      bits   <= '0;
    end else begin
      step   <= step_next;
      locked <= locked_next;
      bits   <= bits_next;
    end
  end

  assign status      = '{locked: locked, bits: bits};
  assign status_next = '{locked: locked_next, bits: bits_next};

endmodule
`default_nettype wire

FILE: hdl/gprb_port_regs.sv
// Mode nibble registers (CRL, CRH) and output data register with set/reset writes.
// Depends on gprb_pkg.
`default_nettype none
module gprb_port_regs import gprb_pkg::*; #(
  parameter int PIN_COUNT = DEF_PIN_COUNT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire logic [2:0]   sel,
  input  wire logic [31:0]  wr_data,
  input  wire lock_status_t lock,
  output logic [63:0]       cfg,
  output logic [15:0]       odr,
  output logic [15:0]       odr_next
);

  localparam logic [15:0] PIN_MASK  = pin_mask(PIN_COUNT);
  localparam logic [63:0] CFG_AVAIL = pins_to_nibbles(PIN_MASK);

  logic [63:0] cfg_next;
  logic [63:0] keep;
  logic [63:0] cfg_wr;

  assign keep   = (lock.locked ? pins_to_nibbles(lock.bits) : 64'd0) | ~CFG_AVAIL;
  assign cfg_wr = ((cfg & keep) | ({wr_data, wr_data} & ~keep)) & CFG_AVAIL;

  always_comb begin
    cfg_next = cfg;
    odr_next = odr;
    if (wr_en) begin
      unique case (sel_t'(sel))
        SEL_CRL:  cfg_next[31:0]  = cfg_wr[31:0];
        SEL_CRH:  cfg_next[63:32] = cfg_wr[63:32];
        SEL_ODR:  odr_next = wr_data[15:0] & PIN_MASK;
        SEL_BSRR: odr_next = ((odr & ~wr_data[31:16]) | wr_data[15:0]) & PIN_MASK;
        SEL_BRR:  odr_next = odr & ~wr_data[15:0] & PIN_MASK;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET & CFG_AVAIL;
      odr <= '0;
    end else begin
      cfg <= cfg_next;
      odr <= odr_next;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/gpio_port_register_block_core.sv
// Top level of the GPIO port register block: read decode and response register.
// Depends on gprb_pkg, gprb_if, gprb_lock and gprb_port_regs.
//
//   Channel  Direction  Word
//   req      in         req_type, reg_select, write_data, pin_levels
//   rsp      out        read_data, output_levels, lock_active
//
// Each accepted request word updates the registers at the accepting edge and
// its response word is held in the response register from the next cycle on.
// A new request is taken every cycle while the response side takes words;
// req.ready is low only while a response waits and rsp.ready is low.
// Reset is synchronous and returns all but the response data to power-on values.
`default_nettype none
module gpio_port_register_block_core import gprb_pkg::*; #(
  parameter int PIN_COUNT = DEF_PIN_COUNT
) (
  input wire logic  clk,
  input wire logic  rst,
  gprb_req_if.sink   req,
  gprb_rsp_if.source rsp
);

  localparam logic [15:0] PIN_MASK = pin_mask(PIN_COUNT);

  logic         accept;
  logic         wr_en;
  lock_status_t lock;
  lock_status_t lock_next;
  logic [63:0]  cfg;
  logic [15:0]  odr;
  logic [15:0]  odr_next;
  logic [31:0]  rd_data;
  logic         rsp_valid;
  rsp_t         rsp_data;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign wr_en     = accept && req.data.req_type;

  gprb_lock #(.PIN_COUNT(PIN_COUNT)) u_lock (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr_en && sel_t'(req.data.reg_select) == SEL_LCKR),
    .wr_data     (req.data.write_data[16:0]),
    .status      (lock),
    .status_next (lock_next)
  );

  gprb_port_regs #(.PIN_COUNT(PIN_COUNT)) u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .sel      (req.data.reg_select),
    .wr_data  (req.data.write_data),
    .lock     (lock),
    .cfg      (cfg),
    .odr      (odr),
    .odr_next (odr_next)
  );

  always_comb begin
    rd_data = '0;
    if (!req.data.req_type) begin
      unique case (sel_t'(req.data.reg_select))
        SEL_CRL:  rd_data = cfg[31:0];
        SEL_CRH:  rd_data = cfg[63:32];
        SEL_IDR:  rd_data = {16'd0, req.data.pin_levels & PIN_MASK};
        SEL_ODR:  rd_data = {16'd0, odr};
        SEL_LCKR: rd_data = {15'd0, lock.locked, lock.bits};
        default:  rd_data = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (accept) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp_data <= '{read_data: rd_data, output_levels: odr_next,
                    lock_active: lock_next.locked};
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

endmodule
`default_nettype wire
